/* hw/rtl/bpfs_pkg.sv */
// Shared constants and types for the bit vector popcount / find-first-set engine.
package bpfs_pkg;

    // Default store geometry
    localparam int WORD_COUNT_DEF = 16;
    localparam int WORD_BITS_DEF  = 64;
    localparam int WORD_BITS_MAX  = 64;

    // Port field widths
    localparam int FUNC_W        = 3;
    localparam int BIT_INDEX_W   = 10;
    localparam int WORD_INDEX_W  = 4;
    localparam int DATA_W        = 64;
    localparam int CFG_LEN_W     = 11;
    localparam int COUNT_W       = 11;
    localparam int FIRST_W       = 11;
    localparam logic [CFG_LEN_W-1:0] LENGTH_RESET = CFG_LEN_W'(1024);

    // Per-word statistics, sized for the widest supported word
    localparam int STAT_ONES_W = $clog2(WORD_BITS_MAX + 1);
    localparam int STAT_POS_W  = $clog2(WORD_BITS_MAX);

    typedef struct packed {
        logic [STAT_ONES_W-1:0] ones;
        logic [STAT_POS_W-1:0]  pos;
        logic                   nonzero;
        logic                   full;
    } stat_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_BIT  = 3'd0,
        FUNC_FLIP_BIT   = 3'd1,
        FUNC_FILL_ALL   = 3'd2,
        FUNC_INVERT_ALL = 3'd3,
        FUNC_AND_WORD   = 3'd4,
        FUNC_OR_WORD    = 3'd5,
        FUNC_XOR_WORD   = 3'd6,
        FUNC_QUERY      = 3'd7
    } func_t;

endpackage

/* hw/rtl/bpfs_word_unit.sv */
// Word statistics unit: masks one store word, counts its ones and finds its lowest set bit.
module bpfs_word_unit #(
    parameter int WORD_BITS = bpfs_pkg::WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] mask,
    output bpfs_pkg::stat_t      stat
);

    localparam int LV = $clog2(WORD_BITS);
    localparam int P  = 1 << LV;
    localparam int OW = bpfs_pkg::STAT_ONES_W;

    logic [WORD_BITS-1:0] masked;
    logic [P-1:0]         padded;
    logic [OW-1:0]        tree [LV+1][P];
    logic [bpfs_pkg::STAT_POS_W-1:0] pos;

    assign masked = word & mask;
    assign padded = P'(masked);

    // Adder tree, one level per halving
    always_comb
    begin
        for (int l = 0; l <= LV; l++)
        begin
            for (int j = 0; j < P; j++)
            begin
                tree[l][j] = '0;
            end
        end
        for (int j = 0; j < P; j++)
        begin
            tree[0][j] = OW'(padded[j]);
        end
        for (int l = 0; l < LV; l++)
        begin
            for (int j = 0; j < (P >> (l + 1)); j++)
            begin
                tree[l+1][j] = tree[l][2*j] + tree[l][2*j+1];
            end
        end
    end

    // Lowest set bit wins
    always_comb
    begin
        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (masked[j])
            begin
                pos = bpfs_pkg::STAT_POS_W'(j);
            end
        end
    end

    assign stat.ones    = tree[LV][0];
    assign stat.pos     = pos;
    assign stat.nonzero = |masked;
    assign stat.full    = (masked == mask);

endmodule

/* hw/rtl/bitmap_popcount_first_set_engine_core.sv */
// Top level of the bit vector engine: store, scan sequencer, accumulators and handshakes.
//
// The bit vector lives in a single-port-write, single-port-read memory of WORD_COUNT words of
// WORD_BITS bits. Every item sweeps the whole store once: each word is read, updated by the
// item's function, written back and passed through one shared word statistics unit, whose
// ones count, lowest set bit and full flag are folded into running totals. A sweep makes
// one store read per cycle; in_ready is low while a sweep is in flight. A finished result
// waits in an output register, so the next item can be taken before it is consumed.
// After reset the block zeroes the store before it is ready; vector_length writes are
// taken at any time and should be made while the block is idle.
module bitmap_popcount_first_set_engine_core #(
    parameter int WORD_COUNT = bpfs_pkg::WORD_COUNT_DEF,
    parameter int WORD_BITS  = bpfs_pkg::WORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bpfs_pkg::CFG_LEN_W-1:0]      cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpfs_pkg::FUNC_W-1:0]         func,
    input  logic [bpfs_pkg::BIT_INDEX_W-1:0]    bit_index,
    input  logic                                bit_value,
    input  logic [bpfs_pkg::WORD_INDEX_W-1:0]   word_index,
    input  logic [bpfs_pkg::DATA_W-1:0]         word_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpfs_pkg::COUNT_W-1:0]        count_true,
    output logic signed [bpfs_pkg::FIRST_W-1:0] first_true,
    output logic                                all_set,
    output logic                                all_clear
);

    localparam int TOTAL = WORD_COUNT * WORD_BITS;
    localparam int AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W = $clog2(TOTAL + 1);
    localparam int IDX_W = $clog2(TOTAL);
    localparam int LW    = (CNT_W > bpfs_pkg::CFG_LEN_W) ? CNT_W : bpfs_pkg::CFG_LEN_W;
    localparam int PW    = $clog2(WORD_BITS);
    localparam int CW    = (AW > bpfs_pkg::WORD_INDEX_W) ? AW : bpfs_pkg::WORD_INDEX_W;
    localparam logic [WORD_BITS-1:0] WORD_ONE  = WORD_BITS'(1);
    localparam logic [LW-1:0]        WB_LW     = LW'(WORD_BITS);
    localparam logic [LW-1:0]        TOTAL_LW  = LW'(TOTAL);
    localparam logic [AW-1:0]        LAST_ADDR = AW'(WORD_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [bpfs_pkg::CFG_LEN_W-1:0] vector_length_reg;

    // Latched item
    bpfs_pkg::func_t                     func_reg;
    logic [bpfs_pkg::BIT_INDEX_W-1:0]    bit_index_reg;
    logic                                bit_value_reg;
    logic [bpfs_pkg::WORD_INDEX_W-1:0]   word_index_reg;
    logic [WORD_BITS-1:0]                word_data_reg;

    // Issue stage
    logic [AW-1:0] addr_reg;
    logic [LW-1:0] base_reg;
    logic          addr_last;

    // Read / update stage
    logic                 p1_valid_reg;
    logic                 p1_last_reg;
    logic [AW-1:0]        p1_addr_reg;
    logic [LW-1:0]        p1_base_reg;
    logic [WORD_BITS-1:0] p1_mask_reg;
    logic                 p1_bit_hit_reg;
    logic [PW-1:0]        p1_bit_pos_reg;
    logic                 p1_word_hit_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    // Accumulate stage
    logic            p2_valid_reg;
    logic            p2_last_reg;
    logic [LW-1:0]   p2_base_reg;
    bpfs_pkg::stat_t p2_stat_reg;

    // Running totals
    logic [CNT_W-1:0] cnt_reg;
    logic             full_reg;
    logic             found_reg;
    logic [IDX_W-1:0] first_reg;

    logic out_valid_reg;
    logic [bpfs_pkg::COUNT_W-1:0] count_true_reg;
    logic [bpfs_pkg::FIRST_W-1:0] first_true_reg;
    logic all_set_reg;
    logic all_clear_reg;

    logic [WORD_BITS-1:0] bit_store_mem [WORD_COUNT];

    logic [LW-1:0]        len_ext;
    logic [LW-1:0]        len_eff;
    logic [LW-1:0]        bit_ext;
    logic [LW-1:0]        bit_off;
    logic [LW-1:0]        left;
    logic                 bit_hit;
    logic                 word_hit;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] bit_sel;
    logic [WORD_BITS-1:0] new_word;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    bpfs_pkg::stat_t      stat;
    logic                 accept;
    logic                 load_out;
    logic [CNT_W+bpfs_pkg::COUNT_W-1:0] cnt_wide;
    logic [IDX_W+bpfs_pkg::FIRST_W-1:0] first_wide;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign addr_last = (addr_reg == LAST_ADDR);
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Clamp the length to the store size
    assign len_ext = LW'(vector_length_reg);
    assign len_eff = (len_ext > TOTAL_LW) ? TOTAL_LW : len_ext;

    // Locate the single-bit target and the valid-bit mask for the word being issued
    assign bit_ext  = LW'(bit_index_reg);
    assign bit_off  = bit_ext - base_reg;
    assign bit_hit  = (bit_ext >= base_reg) && (bit_off < WB_LW);
    assign word_hit = (CW'(word_index_reg) == CW'(addr_reg));
    assign left     = len_eff - base_reg;

    always_comb
    begin
        if (len_eff <= base_reg)
        begin
            mask = '0;
        end
        else if (left >= WB_LW)
        begin
            mask = '1;
        end
        else
        begin
            mask = (WORD_ONE << left[PW-1:0]) - WORD_ONE;
        end
    end

    // Update the word read back from the store
    assign bit_sel = WORD_ONE << p1_bit_pos_reg;

    always_comb
    begin
        unique case (func_reg)
            bpfs_pkg::FUNC_WRITE_BIT:
            begin
                if (!p1_bit_hit_reg)
                begin
                    new_word = rd_data_reg;
                end
                else if (bit_value_reg)
                begin
                    new_word = rd_data_reg | bit_sel;
                end
                else
                begin
                    new_word = rd_data_reg & ~bit_sel;
                end
            end
            bpfs_pkg::FUNC_FLIP_BIT:
                new_word = p1_bit_hit_reg ? (rd_data_reg ^ bit_sel) : rd_data_reg;
            bpfs_pkg::FUNC_FILL_ALL:
                new_word = bit_value_reg ? '1 : '0;
            bpfs_pkg::FUNC_INVERT_ALL:
                new_word = ~rd_data_reg;
            bpfs_pkg::FUNC_AND_WORD:
                new_word = p1_word_hit_reg ? (rd_data_reg & word_data_reg) : rd_data_reg;
            bpfs_pkg::FUNC_OR_WORD:
                new_word = p1_word_hit_reg ? (rd_data_reg | word_data_reg) : rd_data_reg;
            bpfs_pkg::FUNC_XOR_WORD:
                new_word = p1_word_hit_reg ? (rd_data_reg ^ word_data_reg) : rd_data_reg;
            bpfs_pkg::FUNC_QUERY:
                new_word = rd_data_reg;
            default:
                new_word = rd_data_reg;
        endcase
    end

    bpfs_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .word (new_word),
        .mask (p1_mask_reg),
        .stat (stat)
    );

    // Store write port: zeroing sweep after reset, write-back during a scan
    assign wr_en   = (state_reg == ST_CLEAR) || p1_valid_reg;
    assign wr_addr = (state_reg == ST_CLEAR) ? addr_reg : p1_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : new_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bit_store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bit_store_mem[addr_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (p2_valid_reg && p2_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign cnt_wide   = {{bpfs_pkg::COUNT_W{1'b0}}, cnt_reg};
    assign first_wide = {{bpfs_pkg::FIRST_W{1'b0}}, first_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            vector_length_reg <= bpfs_pkg::LENGTH_RESET;
            addr_reg          <= '0;
            base_reg          <= '0;
            p1_valid_reg      <= 1'b0;
            p2_valid_reg      <= 1'b0;
            cnt_reg           <= '0;
            full_reg          <= 1'b1;
            found_reg         <= 1'b0;
            first_reg         <= '0;
            out_valid_reg     <= 1'b0;
            count_true_reg    <= '0;
            first_true_reg    <= '0;
            all_set_reg       <= 1'b0;
            all_clear_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                vector_length_reg <= cfg_wr_data;
            end

            // Advance the word address during the zeroing sweep and the scan
            if ((state_reg == ST_CLEAR) || (state_reg == ST_SCAN))
            begin
                addr_reg <= addr_last ? '0 : addr_reg + AW'(1);
                base_reg <= base_reg + WB_LW;
            end
            else if (accept)
            begin
                addr_reg <= '0;
                base_reg <= '0;
            end

            p1_valid_reg <= (state_reg == ST_SCAN);
            p2_valid_reg <= p1_valid_reg;

            if (accept)
            begin
                cnt_reg   <= '0;
                full_reg  <= 1'b1;
                found_reg <= 1'b0;
                first_reg <= '0;
            end
            else if (p2_valid_reg)
            begin
                cnt_reg  <= cnt_reg + CNT_W'(p2_stat_reg.ones);
                full_reg <= full_reg && p2_stat_reg.full;
                if (!found_reg && p2_stat_reg.nonzero)
                begin
                    found_reg <= 1'b1;
                    first_reg <= IDX_W'(p2_base_reg) + IDX_W'(p2_stat_reg.pos);
                end
            end

            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                count_true_reg <= cnt_wide[bpfs_pkg::COUNT_W-1:0];
                first_true_reg <= found_reg ? first_wide[bpfs_pkg::FIRST_W-1:0] : '1;
                all_set_reg    <= full_reg;
                all_clear_reg  <= (cnt_reg == '0);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload pipeline, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= bpfs_pkg::func_t'(func);
            bit_index_reg  <= bit_index;
            bit_value_reg  <= bit_value;
            word_index_reg <= word_index;
            word_data_reg  <= word_data[WORD_BITS-1:0];
        end
        p1_last_reg     <= addr_last;
        p1_addr_reg     <= addr_reg;
        p1_base_reg     <= base_reg;
        p1_mask_reg     <= mask;
        p1_bit_hit_reg  <= bit_hit;
        p1_bit_pos_reg  <= bit_off[PW-1:0];
        p1_word_hit_reg <= word_hit;
        p2_last_reg     <= p1_last_reg;
        p2_base_reg     <= p1_base_reg;
        p2_stat_reg     <= stat;
    end

    assign out_valid  = out_valid_reg;
    assign count_true = count_true_reg;
    assign first_true = first_true_reg;
    assign all_set    = all_set_reg;
    assign all_clear  = all_clear_reg;

endmodule
